/* hdl/cle_pkg.sv */
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types, constants and helper functions for the character LCD text
// and cursor engine.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int unsigned COL_W     = 6;
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned ROWS_W    = 3;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
  localparam logic [2:0] OP_SET_CURSOR = 3'd1;
  localparam logic [2:0] OP_CLEAR      = 3'd2;
  localparam logic [2:0] OP_HOME       = 3'd3;
  localparam logic [2:0] OP_DISPLAY    = 3'd4;

  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT    = 1'b1;

  localparam logic [COL_W-1:0]  COLUMN_COUNT_RESET = 6'd16;
  localparam logic [ROWS_W-1:0] ROW_COUNT_RESET    = 3'd2;
  localparam logic [ROWS_W-1:0] ROWS_MAX           = 3'd4;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_DISPLAY   = 8'h08;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [COL_W-1:0] COL_LAST = 6'd63;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [7:0]       char_code;
    logic [COL_W-1:0] target_col;
    logic [ROW_W-1:0] target_row;
    logic             display_on;
    logic             cursor_on;
    logic             blink_on;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last_word;
  } rsp_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] count;
    rsp_t       word0;
    rsp_t       word1;
  } push_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [7:0]       cmd;
  } move_t;

  function automatic logic [6:0] row_base(input logic [ROW_W-1:0] row);
    logic [6:0] base;
    unique case (row)
      2'd0:    base = 7'h00;
      2'd1:    base = 7'h40;
      2'd2:    base = 7'h14;
      default: base = 7'h54;
    endcase
    return base;
  endfunction

  function automatic logic [ROWS_W-1:0] rows_effective(input logic [ROWS_W-1:0] rows);
    logic [ROWS_W-1:0] r;
    if (rows == '0) begin
      r = 3'd1;
    end else if (rows > ROWS_MAX) begin
      r = ROWS_MAX;
    end else begin
      r = rows;
    end
    return r;
  endfunction

  function automatic move_t ddram_move(input logic [COL_W-1:0]  col,
                                       input logic [ROWS_W-1:0] row,
                                       input logic [ROWS_W-1:0] rows_eff);
    move_t             m;
    logic [ROWS_W-1:0] r;
    r = (row >= rows_eff) ? rows_eff - 3'd1 : row;
    m.row = r[ROW_W-1:0];
    m.cmd = CMD_SET_DDRAM | ({2'b00, col} + {1'b0, row_base(r[ROW_W-1:0])});
    return m;
  endfunction

endpackage

/* hdl/cle_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cle_cfg_regs
// APB register file holding the display geometry.
// ----------------------------------------------------------------------------
module cle_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cle_pkg::PADDR_W-1:0] paddr,
  input  logic [cle_pkg::PDATA_W-1:0] pwdata,
  output logic [cle_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [cle_pkg::COL_W-1:0]   column_count,
  output logic [cle_pkg::ROWS_W-1:0]  row_count
);
  import cle_pkg::*;

  logic write_en;
  logic reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign write_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= COLUMN_COUNT_RESET;
      row_count    <= ROW_COUNT_RESET;
    end else if (write_en) begin
      unique case (reg_index)
        REG_COLUMN_COUNT: column_count <= pwdata[COL_W-1:0];
        REG_ROW_COUNT:    row_count    <= pwdata[ROWS_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      REG_COLUMN_COUNT: prdata[COL_W-1:0]  = column_count;
      REG_ROW_COUNT:    prdata[ROWS_W-1:0] = row_count;
      default:          prdata = '0;
    endcase
  end

endmodule

/* hdl/cle_engine.sv */
// ----------------------------------------------------------------------------
// cle_engine
// Input register, cursor state and bus word generation for one command.
// ----------------------------------------------------------------------------
module cle_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  cle_pkg::req_t              req_data,
  input  logic [cle_pkg::COL_W-1:0]  column_count,
  input  logic [cle_pkg::ROWS_W-1:0] row_count,
  input  logic                       can_push,
  output cle_pkg::push_t             push
);
  import cle_pkg::*;

  logic              hold_valid;
  req_t              hold_data;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col_next;
  logic [ROW_W-1:0]  cursor_row_next;
  logic              fire;
  logic [ROWS_W-1:0] rows_eff;
  logic [ROWS_W-1:0] row_down;
  logic [COL_W-1:0]  col_inc;
  move_t             move_down;
  move_t             move_target;

  assign fire      = hold_valid && can_push;
  assign req_ready = !hold_valid || can_push;
  assign rows_eff  = rows_effective(row_count);
  assign row_down  = {1'b0, cursor_row} + 3'd1;
  assign col_inc   = (cursor_col == COL_LAST) ? COL_LAST : cursor_col + 6'd1;
  assign move_down = ddram_move('0, row_down, rows_eff);
  assign move_target = ddram_move(hold_data.target_col, {1'b0, hold_data.target_row},
                                  rows_eff);

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    push.valid      = fire;
    push.count      = 2'd0;
    push.word0      = '{reg_select: RS_COMMAND, bus_byte: 8'h00, last_word: 1'b1};
    push.word1      = '{reg_select: RS_DATA, bus_byte: hold_data.char_code,
                        last_word: 1'b1};
    unique case (hold_data.opcode)
      OP_PUT_CHAR: begin
        if (hold_data.char_code == CHAR_NEWLINE) begin
          push.count          = 2'd1;
          push.word0.bus_byte = move_down.cmd;
          cursor_col_next     = '0;
          cursor_row_next     = move_down.row;
        end else if (cursor_col >= column_count) begin
          push.count           = 2'd2;
          push.word0.bus_byte  = move_down.cmd;
          push.word0.last_word = 1'b0;
          cursor_col_next      = 6'd1;
          cursor_row_next      = move_down.row;
        end else begin
          push.count            = 2'd1;
          push.word0.reg_select = RS_DATA;
          push.word0.bus_byte   = hold_data.char_code;
          cursor_col_next       = col_inc;
        end
      end
      OP_SET_CURSOR: begin
        push.count          = 2'd1;
        push.word0.bus_byte = move_target.cmd;
        cursor_col_next     = hold_data.target_col;
        cursor_row_next     = move_target.row;
      end
      OP_CLEAR: begin
        push.count          = 2'd1;
        push.word0.bus_byte = CMD_CLEAR;
        cursor_col_next     = '0;
        cursor_row_next     = '0;
      end
      OP_HOME: begin
        push.count          = 2'd1;
        push.word0.bus_byte = CMD_HOME;
        cursor_col_next     = '0;
        cursor_row_next     = '0;
      end
      OP_DISPLAY: begin
        push.count          = 2'd1;
        push.word0.bus_byte = CMD_DISPLAY | {5'd0, hold_data.display_on,
                                             hold_data.cursor_on, hold_data.blink_on};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      if (req_ready) begin
        hold_valid <= req_valid;
      end
      if (fire) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold_data <= req_data;
    end
  end

`ifndef SYNTHESIS
  a_clear_home_zero: assert property (@(posedge clk) disable iff (rst)
    fire && (hold_data.opcode == OP_CLEAR || hold_data.opcode == OP_HOME)
    |=> cursor_col == '0 && cursor_row == '0)
    else $error("cursor not reset by clear or home");

  a_hold_waits: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !can_push |=> hold_valid && $stable(hold_data))
    else $error("held command lost while output queue full");
`endif

endmodule

/* hdl/cle_out_fifo.sv */
// ----------------------------------------------------------------------------
// cle_out_fifo
// Four-entry queue of bus words, taking up to two words per cycle while it
// has two free entries and giving one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module cle_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  cle_pkg::push_t push,
  output logic           can_push,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cle_pkg::rsp_t  rsp_data
);
  import cle_pkg::*;

  rsp_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_CNT_W-1:0] push_n;
  logic                  pop;

  assign can_push  = count <= 3'd2;
  assign rsp_valid = count != '0;
  assign rsp_data  = entries[rptr];
  assign pop       = rsp_valid && rsp_ready;
  assign push_n    = push.valid ? {1'b0, push.count} : 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push_n[FIFO_PTR_W-1:0];
      rptr  <= rptr + {1'b0, pop};
      count <= count + push_n - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && push.count != 2'd0) begin
      entries[wptr] <= push.word0;
    end
    if (push.valid && push.count == 2'd2) begin
      entries[wptr + 2'd1] <= push.word1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> count <= 3'd2)
    else $error("push into queue without room");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("queue count out of range");

  a_pair_marking: assert property (@(posedge clk) disable iff (rst)
    push.valid && push.count == 2'd2 |-> !push.word0.last_word && push.word1.last_word)
    else $error("two-word transaction marked wrongly");
`endif

endmodule

/* hdl/char_lcd_text_cursor_engine.sv */
// ----------------------------------------------------------------------------
// char_lcd_text_cursor_engine
// Turns text and cursor commands into HD44780 bus words.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   cle_pkg::req_t
//   rsp      out        rsp_valid/rsp_ready   cle_pkg::rsp_t
//   apb      in         psel/penable/pready   column_count, row_count
//
// A command is registered in a hold register; its words are built from it
// combinationally and written into a four-entry output queue, whose head
// drives the port. A command gives zero, one or two words; the one-word
// output port sets the rate at one word per cycle while rsp_ready is high;
// a wrapped character gives two words. A queue with under two free entries
// stalls the input. Reset clears the cursor and queue and restores geometry.
// ----------------------------------------------------------------------------
module char_lcd_text_cursor_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  cle_pkg::req_t               req_data,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output cle_pkg::rsp_t               rsp_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cle_pkg::PADDR_W-1:0] paddr,
  input  logic [cle_pkg::PDATA_W-1:0] pwdata,
  output logic [cle_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import cle_pkg::*;

  logic [COL_W-1:0]  column_count;
  logic [ROWS_W-1:0] row_count;
  logic              can_push;
  push_t             push;

  cle_cfg_regs u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .column_count (column_count),
    .row_count    (row_count)
  );

  cle_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_data     (req_data),
    .column_count (column_count),
    .row_count    (row_count),
    .can_push     (can_push),
    .push         (push)
  );

  cle_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .can_push  (can_push),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule
